FILE: rtl/epf_pkg.sv
// epf_pkg: types and constants shared by the euler path block
// depends on nothing
`default_nettype none
package epf_pkg;
    localparam int MaxVertices = 8;
    localparam int VtxW = 3;
    localparam int CntW = 4;
    localparam int MaxResults = 29;
    localparam logic [CntW-1:0] NoVertex = 4'd15;
    localparam logic [CntW-1:0] CountReset = 4'd8;

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE, S_EMIT, S_SCAN, S_BRINIT, S_BRSTEP, S_BRDONE, S_TAKE, S_LAST
    } t_state;

    typedef struct packed {
        logic load_item;
        logic do_edge;
        logic scan_init;
        logic scan_adv;
        logic br_init;
        logic br_step;
        logic take;
        logic note_bridge;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic scan_edge;
        logic br_done;
        logic bridge_hit;
        logic have_next;
        logic start_ok;
        logic cap_hit;
    } t_sts;
endpackage
`default_nettype wire

FILE: rtl/epf_ctrl.sv
// epf_ctrl: walk sequencer state machine
// depends on epf_pkg
`default_nettype none
module epf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire logic          i_mode,
    input  wire logic          i_out_free,
    input  wire epf_pkg::t_sts i_sts,
    output epf_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_emit,
    output logic               o_emit_last
);
    epf_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= epf_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            epf_pkg::S_IDLE: if (i_go) n_state = i_mode ? epf_pkg::S_EMIT : epf_pkg::S_EDGE;
            epf_pkg::S_EDGE: n_state = epf_pkg::S_IDLE;
            epf_pkg::S_EMIT: begin
                if (!i_sts.start_ok) begin
                    if (i_out_free) n_state = epf_pkg::S_IDLE;
                end else begin
                    n_state = epf_pkg::S_SCAN;
                end
            end
            epf_pkg::S_SCAN: begin
                if (i_sts.scan_done)      n_state = epf_pkg::S_TAKE;
                else if (i_sts.scan_edge) n_state = epf_pkg::S_BRINIT;
            end
            epf_pkg::S_BRINIT: n_state = epf_pkg::S_BRSTEP;
            epf_pkg::S_BRSTEP: if (i_sts.br_done) n_state = epf_pkg::S_BRDONE;
            epf_pkg::S_BRDONE: n_state = i_sts.bridge_hit ? epf_pkg::S_SCAN : epf_pkg::S_TAKE;
            epf_pkg::S_TAKE: begin
                if (!i_sts.have_next) n_state = epf_pkg::S_LAST;
                else if (i_out_free)  n_state = i_sts.cap_hit ? epf_pkg::S_LAST
                                                              : epf_pkg::S_SCAN;
            end
            epf_pkg::S_LAST: if (i_out_free) n_state = epf_pkg::S_IDLE;
            default: n_state = epf_pkg::S_IDLE;
        endcase
    end

    // command decode, each vertex goes out once the next step is known
    always_comb begin
        o_cmd = '0;
        o_emit = 1'b0;
        o_emit_last = 1'b0;
        o_busy = (r_state != epf_pkg::S_IDLE);
        unique case (r_state)
            epf_pkg::S_IDLE: o_cmd.load_item = i_go;
            epf_pkg::S_EDGE: o_cmd.do_edge = 1'b1;
            epf_pkg::S_EMIT: begin
                if (!i_sts.start_ok) begin
                    o_emit = i_out_free;
                    o_emit_last = 1'b1;
                end else begin
                    o_cmd.scan_init = 1'b1;
                end
            end
            epf_pkg::S_SCAN: o_cmd.scan_adv = !i_sts.scan_done && !i_sts.scan_edge;
            epf_pkg::S_BRINIT: o_cmd.br_init = 1'b1;
            epf_pkg::S_BRSTEP: o_cmd.br_step = !i_sts.br_done;
            epf_pkg::S_BRDONE: begin
                o_cmd.note_bridge = i_sts.bridge_hit;
                o_cmd.scan_adv = i_sts.bridge_hit;
            end
            epf_pkg::S_TAKE: begin
                if (i_sts.have_next && i_out_free) begin
                    o_emit = 1'b1;
                    o_cmd.take = 1'b1;
                end
            end
            epf_pkg::S_LAST: begin
                o_emit = i_out_free;
                o_emit_last = 1'b1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/epf_data.sv
// epf_data: adjacency matrix, neighbour scan and bridge search datapath
// depends on epf_pkg
`default_nettype none
module epf_data (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire epf_pkg::t_cmd              i_cmd,
    input  wire logic [epf_pkg::VtxW-1:0]   i_vertex_a,
    input  wire logic [epf_pkg::VtxW-1:0]   i_vertex_b,
    input  wire logic                       i_edge_present,
    input  wire logic [epf_pkg::CntW-1:0]   i_count,
    output epf_pkg::t_sts                   o_sts,
    output logic [epf_pkg::VtxW-1:0]        o_cur
);
    localparam int N = epf_pkg::MaxVertices;
    localparam int VW = epf_pkg::VtxW;
    localparam int CW = epf_pkg::CntW;
    localparam int RW = $clog2(epf_pkg::MaxResults + 1);

    logic [N-1:0]    r_adj [N];
    logic [VW-1:0]   r_a, r_b, r_cur;
    logic            r_pres;
    logic [CW-1:0]   r_to, r_fb;
    logic [RW-1:0]   r_res;
    // bridge search state
    logic [N-1:0]    r_vis;
    logic [VW-1:0]   r_disc [N];
    logic [VW-1:0]   r_low  [N];
    logic [VW-1:0]   r_sv   [N];
    logic [CW-1:0]   r_ss   [N];
    logic [CW-1:0]   r_sp_par [N];
    logic [CW-1:0]   r_sp;
    logic [CW-1:0]   r_ord;
    logic            r_found;

    logic [CW-1:0]   w_act;
    logic [VW-1:0]   w_top, w_v, w_u, w_t3;
    logic [CW-1:0]   w_t;
    logic            w_nbr_edge, w_done_edge;
    logic [VW-1:0]   w_next;

    // active vertex count, limited to the matrix size
    assign w_act = (i_count > CW'(N)) ? CW'(N) : i_count;

    assign w_top = VW'(r_sp - 1'b1);
    assign w_v   = r_sv[w_top];
    assign w_t   = r_ss[w_top];
    assign w_t3  = w_t[VW-1:0];
    assign w_u   = r_sv[VW'(r_sp - 4'd2)];

    assign w_nbr_edge  = (r_to < w_act) && r_adj[r_cur][r_to[VW-1:0]];
    assign w_done_edge = (r_to >= w_act);

    assign o_sts.scan_done  = w_done_edge;
    assign o_sts.scan_edge  = w_nbr_edge;
    assign o_sts.br_done    = (r_sp == '0);
    assign o_sts.bridge_hit = r_found;
    assign o_sts.have_next  = !w_done_edge || (r_fb != epf_pkg::NoVertex);
    assign o_sts.start_ok   = ({1'b0, r_a} < w_act);
    assign o_sts.cap_hit    = (r_res == RW'(epf_pkg::MaxResults - 1));
    assign o_cur  = r_cur;
    assign w_next = w_done_edge ? r_fb[VW-1:0] : r_to[VW-1:0];

    // item latch, scan, adjacency updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) r_adj[i] <= '0;
            r_fb <= epf_pkg::NoVertex;
            r_a <= '0;
            r_b <= '0;
            r_pres <= 1'b0;
            r_cur <= '0;
            r_to <= '0;
            r_res <= '0;
        end else begin
            if (i_cmd.load_item) begin
                r_a <= i_vertex_a;
                r_b <= i_vertex_b;
                r_pres <= i_edge_present;
                r_cur <= i_vertex_a;
            end
            if (i_cmd.do_edge && ({1'b0, r_a} < w_act) && ({1'b0, r_b} < w_act)) begin
                r_adj[r_a][r_b] <= r_pres;
                r_adj[r_b][r_a] <= r_pres;
            end
            if (i_cmd.scan_init) begin
                r_to <= '0;
                r_fb <= epf_pkg::NoVertex;
                r_res <= RW'(1);
            end
            if (i_cmd.scan_adv) r_to <= r_to + 1'b1;
            if (i_cmd.note_bridge) r_fb <= r_to;
            if (i_cmd.take) begin
                r_adj[r_cur][w_next] <= 1'b0;
                r_adj[w_next][r_cur] <= 1'b0;
                r_cur <= w_next;
                r_to <= '0;
                r_fb <= epf_pkg::NoVertex;
                r_res <= r_res + 1'b1;
            end
        end
    end

    // iterative tarjan search, one stack action per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_cmd.br_init) begin
            r_vis <= N'(1) << r_cur;
            r_disc[r_cur] <= '0;
            r_low[r_cur] <= '0;
            r_ord <= 4'd1;
            r_sv[0] <= r_cur;
            r_ss[0] <= '0;
            r_sp_par[0] <= epf_pkg::NoVertex;
            r_sp <= 4'd1;
            r_found <= 1'b0;
        end else if (i_cmd.br_step) begin
            if (w_t >= w_act) begin
                r_sp <= r_sp - 1'b1;
                if (r_sp > 4'd1) begin
                    if (r_low[w_v] < r_low[w_u]) r_low[w_u] <= r_low[w_v];
                    if ((r_disc[w_u] < r_low[w_v]) &&
                        ((w_u == r_cur && {1'b0, w_v} == r_to) ||
                         ({1'b0, w_u} == r_to && w_v == r_cur)))
                        r_found <= 1'b1;
                end
            end else begin
                r_ss[w_top] <= w_t + 1'b1;
                if (r_adj[w_v][w_t3] && (w_t != r_sp_par[w_top])) begin
                    if (!r_vis[w_t3]) begin
                        if (r_sp < CW'(N)) begin
                            r_disc[w_t3] <= r_ord[VW-1:0];
                            r_low[w_t3] <= r_ord[VW-1:0];
                            r_ord <= r_ord + 1'b1;
                            r_vis[w_t3] <= 1'b1;
                            r_sv[r_sp[VW-1:0]] <= w_t3;
                            r_ss[r_sp[VW-1:0]] <= '0;
                            r_sp_par[r_sp[VW-1:0]] <= {1'b0, w_v};
                            r_sp <= r_sp + 1'b1;
                        end
                    end else if (r_disc[w_t3] < r_low[w_v]) begin
                        r_low[w_v] <= r_disc[w_t3];
                    end
                end
            end
        end
    end

    // the search stack never exceeds the matrix size
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CW'(N)) else $error("search stack overflow");
    // a walked edge is gone in the next cycle
    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |=> !r_adj[$past(r_cur)][$past(w_next)])
        else $error("walked edge not cleared");
    // the matrix stays symmetric at the latched item's vertex pair
    a_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_adj[r_a][r_b] == r_adj[r_b][r_a]) else $error("matrix asymmetric");
endmodule
`default_nettype wire

FILE: rtl/euler_path_fleury_top.sv
// Fleury euler walk block over an 8-vertex adjacency matrix. A mode 0 word sets or
// clears one edge. A mode 1 word walks from its start vertex and emits the start and
// each vertex reached, the final one marked; a vertex goes out once the step after it
// is known. For every edge tried at a vertex a Tarjan bridge search runs one stack
// step per cycle. One item is worked at a time; the result register frees the walk
// from the consumer except when a word is still unclaimed.
// depends on epf_pkg, epf_ctrl, epf_data
`default_nettype none
module euler_path_fleury_top (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic                     i_mode,
    input  wire logic [epf_pkg::VtxW-1:0] i_vertex_a,
    input  wire logic [epf_pkg::VtxW-1:0] i_vertex_b,
    input  wire logic                     i_edge_present,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [epf_pkg::VtxW-1:0]      o_path_vertex,
    output logic                          o_last_vertex,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [epf_pkg::CntW-1:0] i_cfg_vertex_count
);
    epf_pkg::t_cmd w_cmd;
    epf_pkg::t_sts w_sts;
    logic w_busy, w_emit, w_emit_last, w_out_free;
    logic [epf_pkg::VtxW-1:0] w_cur;
    logic [epf_pkg::CntW-1:0] r_count;
    logic r_valid;

    assign o_ready = !w_busy;
    assign o_cfg_ready = 1'b1;
    assign w_out_free = !r_valid || i_ready;
    assign o_valid = r_valid;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_count <= epf_pkg::CountReset;
        else if (i_cfg_valid) r_count <= i_cfg_vertex_count;
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_out_free) begin
            r_valid <= w_emit;
            if (w_emit) begin
                o_path_vertex <= w_cur;
                o_last_vertex <= w_emit_last;
            end
        end
    end

    epf_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_go(i_valid && !w_busy), .i_mode, .i_out_free(w_out_free),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(w_busy),
        .o_emit(w_emit), .o_emit_last(w_emit_last)
    );

    epf_data u_data (
        .i_clk, .i_rst_n, .i_cmd(w_cmd),
        .i_vertex_a, .i_vertex_b, .i_edge_present, .i_count(r_count),
        .o_sts(w_sts), .o_cur(w_cur)
    );
endmodule
`default_nettype wire

FILE: tb/sv/tb_euler_path_fleury_top.sv
// testbench for euler_path_fleury_top: edge words build graphs, walk words are checked
// against a local fleury walk predictor with a tarjan bridge search
// depends on epf_pkg and the euler path rtl
`timescale 1ns / 1ps
module tb_euler_path_fleury_top;

    localparam int EDGE_OP = 0;
    localparam int WALK_OP = 1;
    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic                     mode;
        logic [epf_pkg::VtxW-1:0] va;
        logic [epf_pkg::VtxW-1:0] vb;
        logic                     present;
    } t_graph_word;

    typedef struct {
        logic [epf_pkg::VtxW-1:0] vtx;
        logic                     last;
    } t_path_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_mode = 1'b0;
    logic [epf_pkg::VtxW-1:0] i_vertex_a = '0;
    logic [epf_pkg::VtxW-1:0] i_vertex_b = '0;
    logic i_edge_present = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [epf_pkg::VtxW-1:0] o_path_vertex;
    logic o_last_vertex;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [epf_pkg::CntW-1:0] i_cfg_vertex_count = '0;

    euler_path_fleury_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_vertex_a(i_vertex_a), .i_vertex_b(i_vertex_b),
        .i_edge_present(i_edge_present),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_path_vertex(o_path_vertex), .o_last_vertex(o_last_vertex),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_vertex_count(i_cfg_vertex_count)
    );

    // predictor state
    logic [7:0] graph_adj[epf_pkg::MaxVertices];
    logic [epf_pkg::CntW-1:0] model_count = epf_pkg::CountReset;

    t_graph_word pending_words[$];
    t_path_word  path_q[$];
    int words_queued = 0;
    int words_taken = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    bit gaps_on = 1'b1;
    bit long_hold_req = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    int recv_hold = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int live_count();
        return (model_count > epf_pkg::MaxVertices) ? epf_pkg::MaxVertices
                                                    : int'(model_count);
    endfunction

    // tarjan search rooted at a; returns 1 when a-b is a bridge
    function automatic bit edge_is_bridge(int a, int b, int n);
        int disc[8];
        int low[8];
        int stk_v[8];
        int stk_scan[8];
        int stk_par[8];
        logic [7:0] seen;
        int sp, order, top, v, t, u;
        bit found;
        found = 0;
        seen = '0;
        order = 0;
        disc[a] = 0;
        low[a] = 0;
        order = 1;
        seen[a] = 1'b1;
        stk_v[0] = a;
        stk_scan[0] = 0;
        stk_par[0] = epf_pkg::NoVertex;
        sp = 1;
        while (sp > 0) begin
            top = sp - 1;
            v = stk_v[top];
            t = stk_scan[top];
            if (t >= n) begin
                sp = top;
                if (sp > 0) begin
                    u = stk_v[sp-1];
                    if (low[v] < low[u]) low[u] = low[v];
                    if (disc[u] < low[v] && ((u == a && v == b) || (u == b && v == a)))
                        found = 1;
                end
            end else begin
                stk_scan[top] = t + 1;
                if (graph_adj[v][t] && t != stk_par[top]) begin
                    if (!seen[t]) begin
                        if (sp < epf_pkg::MaxVertices) begin
                            disc[t] = order;
                            low[t] = order;
                            order++;
                            seen[t] = 1'b1;
                            stk_v[sp] = t;
                            stk_scan[sp] = 0;
                            stk_par[sp] = v;
                            sp++;
                        end
                    end else if (disc[t] < low[v]) begin
                        low[v] = disc[t];
                    end
                end
            end
        end
        return found;
    endfunction

    function automatic void write_edge(int u, int v, logic on);
        graph_adj[u][v] = on;
        graph_adj[v][u] = on;
    endfunction

    // apply one accepted word to the graph and queue the walk it produces
    function automatic void predict_word(t_graph_word w);
        int n, cur, nxt, fall, cnt, to;
        t_path_word pw;
        n = live_count();
        if (w.mode == 1'(EDGE_OP)) begin
            if (w.va < n && w.vb < n) write_edge(w.va, w.vb, w.present);
            return;
        end
        cur = w.va;
        cnt = 1;
        pw.vtx = w.va;
        pw.last = 1'b0;
        if (w.va < n) begin
            while (cnt < epf_pkg::MaxResults) begin
                nxt = epf_pkg::NoVertex;
                fall = epf_pkg::NoVertex;
                for (to = 0; to < n; to++) begin
                    if (graph_adj[cur][to]) begin
                        if (edge_is_bridge(cur, to, n)) fall = to;
                        else begin
                            nxt = to;
                            break;
                        end
                    end
                end
                if (nxt == epf_pkg::NoVertex) nxt = fall;
                if (nxt == epf_pkg::NoVertex) break;
                write_edge(cur, nxt, 1'b0);
                path_q.push_back(pw);
                pw.vtx = nxt[epf_pkg::VtxW-1:0];
                cur = nxt;
                cnt++;
            end
        end
        pw.last = 1'b1;
        path_q.push_back(pw);
    endfunction

    // sender: one word in flight, random gap bursts
    always @(posedge i_clk) begin
        t_graph_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                w.mode = i_mode;
                w.va = i_vertex_a;
                w.vb = i_vertex_b;
                w.present = i_edge_present;
                predict_word(w);
                words_taken++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    w = pending_words.pop_front();
                    i_mode <= w.mode;
                    i_vertex_a <= w.va;
                    i_vertex_b <= w.vb;
                    i_edge_present <= w.present;
                    i_valid <= 1'b1;
                    if (gaps_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: ready with random bursts of stall and one long hold
    always @(posedge i_clk) begin
        t_path_word e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (path_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: vertex %0d last %0d",
                                 o_path_vertex, o_last_vertex);
                end else begin
                    e = path_q.pop_front();
                    if (o_path_vertex !== e.vtx || o_last_vertex !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("path mismatch: exp vertex %0d last %0d, got %0d %0d",
                                     e.vtx, e.last, o_path_vertex, o_last_vertex);
                    end
                end
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                recv_hold = 400;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 4);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("[euler_path_fleury_top] ERROR");
            $finish;
        end
    end

    task automatic push_word(int mode, int a, int b, int p);
        t_graph_word w;
        w.mode = mode[0];
        w.va = a[epf_pkg::VtxW-1:0];
        w.vb = b[epf_pkg::VtxW-1:0];
        w.present = p[0];
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic drain();
        while (words_taken != words_queued || path_q.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_count(logic [epf_pkg::CntW-1:0] c);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_vertex_count <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_count = c;
        i_cfg_valid <= 1'b0;
    endtask

    // random graph then walk; mostly in range, some noise
    task automatic random_rounds(int rounds, int density);
        int n, k, a, b;
        for (int r = 0; r < rounds; r++) begin
            n = live_count();
            if (n == 0) n = 1;
            k = $urandom_range(1, density);
            for (int j = 0; j < k; j++) begin
                if ($urandom_range(0, 7) == 0) begin
                    a = $urandom_range(0, 7);
                    b = $urandom_range(0, 7);
                end else begin
                    a = $urandom_range(0, n - 1);
                    b = $urandom_range(0, n - 1);
                end
                push_word(EDGE_OP, a, b, ($urandom_range(0, 5) != 0));
            end
            a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, n - 1);
            push_word(WALK_OP, a, $urandom_range(0, 7), $urandom_range(0, 1));
        end
    endtask

    initial begin
        for (int i = 0; i < epf_pkg::MaxVertices; i++) graph_adj[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: extremes, self loop, removal, isolated start
        push_word(EDGE_OP, 0, 7, 1);
        push_word(EDGE_OP, 7, 7, 1);
        push_word(WALK_OP, 0, 7, 0);
        push_word(EDGE_OP, 2, 5, 0);
        push_word(WALK_OP, 3, 0, 1);
        push_word(EDGE_OP, 1, 2, 1);
        push_word(EDGE_OP, 2, 3, 1);
        push_word(EDGE_OP, 3, 1, 1);
        push_word(EDGE_OP, 3, 4, 1);
        push_word(EDGE_OP, 6, 6, 1);
        push_word(EDGE_OP, 6, 6, 0);
        push_word(WALK_OP, 4, 0, 0);
        drain();

        // dense graph: walk cut off at the result cap
        for (int a = 0; a < 8; a++)
            for (int b = a; b < 8; b++) push_word(EDGE_OP, a, b, 1);
        push_word(WALK_OP, 0, 0, 0);
        push_word(WALK_OP, 5, 0, 0);
        drain();

        // endpoints and start out of range
        write_count(4'd5);
        push_word(EDGE_OP, 6, 1, 1);
        push_word(EDGE_OP, 1, 5, 1);
        push_word(EDGE_OP, 1, 4, 1);
        push_word(WALK_OP, 6, 0, 0);
        push_word(WALK_OP, 1, 0, 0);
        drain();

        // zero count
        write_count(4'd0);
        push_word(EDGE_OP, 0, 1, 1);
        push_word(WALK_OP, 0, 0, 0);
        push_word(WALK_OP, 7, 7, 1);
        drain();

        write_count(4'd1);
        push_word(EDGE_OP, 0, 0, 1);
        push_word(EDGE_OP, 0, 1, 1);
        push_word(WALK_OP, 0, 0, 0);
        random_rounds(4, 3);
        drain();

        // long receiver hold while walks queue up
        write_count(4'd15);
        long_hold_req = 1'b1;
        random_rounds(12, 10);
        drain();

        write_count(4'd3);
        random_rounds(12, 5);
        drain();

        write_count(4'd6);
        random_rounds(10, 9);
        drain();

        // last part with no idling
        write_count(4'd8);
        gaps_on = 1'b0;
        random_rounds(10, 12);
        drain();
        repeat (50) @(posedge i_clk);

        if (mismatches == 0 && path_q.size() == 0)
            $display("[euler_path_fleury_top] OK");
        else
            $display("[euler_path_fleury_top] ERROR");
        $finish;
    end
endmodule

FILE: sim.f
rtl/epf_pkg.sv
rtl/epf_ctrl.sv
rtl/epf_data.sv
rtl/euler_path_fleury_top.sv
tb/sv/tb_euler_path_fleury_top.sv
